// File: hdl/pvcp_pkg.sv
`default_nettype none
package pvcp_pkg;

	// Field widths fixed by the stream format.
	localparam int unsigned COEF_W     = 16;
	localparam int unsigned CVAL_W     = 11;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SUM_W      = 28;
	localparam int unsigned PROD_W     = 49;
	localparam int unsigned ACC_W      = 7;
	localparam int unsigned ACC_CNT_W  = 3;

	// Configuration register file.
	localparam int unsigned CFG_DATA_W   = 21;
	localparam int unsigned REG_INDEX_W  = 3;
	localparam int unsigned CBITS_W      = 4;
	localparam int unsigned ROUND_W      = 13;
	localparam int unsigned MULT_W       = 21;
	localparam int unsigned SHIFT_W      = 6;
	localparam int unsigned MOD_W        = 13;

	localparam logic [CBITS_W-1:0] CBITS_RESET = 4'd10;
	localparam logic [ROUND_W-1:0] ROUND_RESET = 13'd1665;
	localparam logic [MULT_W-1:0]  MULT_RESET  = 21'd1290167;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd32;
	localparam logic [MOD_W-1:0]   MOD_RESET   = 13'd3329;

	localparam logic [CBITS_W-1:0] CBITS_WIDE = 4'd11;

	// Depth of the queue between the arithmetic front and the packer.
	localparam int unsigned FIFO_DEPTH = 4;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_COMPRESSED_BITS    = 3'd0,
		REG_ROUNDING_OFFSET    = 3'd1,
		REG_BARRETT_MULTIPLIER = 3'd2,
		REG_PRODUCT_SHIFT      = 3'd3,
		REG_MODULUS            = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic                     last_coefficient;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              last_byte;
	} out_item_t;

	// One compressed coefficient on its way to the packer.
	typedef struct packed {
		logic [CVAL_W-1:0] value;
		logic              wide;
		logic              last;
	} cval_t;

endpackage
`default_nettype wire

// File: hdl/pvcp_front.sv
`default_nettype none
module pvcp_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [pvcp_pkg::REG_INDEX_W-1:0]  wr_index,
	input  wire logic [pvcp_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire logic                              push,
	output logic                                   full,
	input  wire pvcp_pkg::in_item_t                item,
	output logic                                   cv_push,
	input  wire logic                              cv_full,
	output pvcp_pkg::cval_t                        cv_data
);
	import pvcp_pkg::*;

	logic [CBITS_W-1:0] cbits_q;
	logic [ROUND_W-1:0] round_q;
	logic [MULT_W-1:0]  mult_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [MOD_W-1:0]   mod_q;

	logic              valid_s1, valid_s2;
	logic [SUM_W-1:0]  sum_s1;
	logic              wide_s1, last_s1;
	logic [PROD_W-1:0] prod_s2;
	logic              wide_s2, last_s2;

	logic              wide_in;
	logic [COEF_W-1:0] coef_u;
	logic [COEF_W-1:0] coef_fix;
	logic [SUM_W-2:0]  coef_shl;
	logic [SUM_W-1:0]  sum_in;
	logic [PROD_W-1:0] prod_shr;
	logic              ready_s2, ready_s1, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbits_q <= CBITS_RESET;
			round_q <= ROUND_RESET;
			mult_q  <= MULT_RESET;
			shift_q <= SHIFT_RESET;
			mod_q   <= MOD_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_COMPRESSED_BITS:    cbits_q <= wr_data[CBITS_W-1:0];
				REG_ROUNDING_OFFSET:    round_q <= wr_data[ROUND_W-1:0];
				REG_BARRETT_MULTIPLIER: mult_q  <= wr_data[MULT_W-1:0];
				REG_PRODUCT_SHIFT:      shift_q <= wr_data[SHIFT_W-1:0];
				REG_MODULUS:            mod_q   <= wr_data[MOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Negative coefficients are lifted by the modulus with 16-bit wrap.
	assign wide_in  = (cbits_q >= CBITS_WIDE);
	assign coef_u   = item.coefficient;
	assign coef_fix = item.coefficient[COEF_W-1] ?
		coef_u + {{(COEF_W-MOD_W){1'b0}}, mod_q} : coef_u;
	assign coef_shl = wide_in ? {coef_fix, 11'b0} : {1'b0, coef_fix, 10'b0};
	assign sum_in   = {1'b0, coef_shl} + {{(SUM_W-ROUND_W){1'b0}}, round_q};

	assign ready_s2 = !valid_s2 || !cv_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full     = !ready_s1;
	assign accept   = push && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= push;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1  <= sum_in;
			wide_s1 <= wide_in;
			last_s1 <= item.last_coefficient;
		end
		if (ready_s2 && valid_s1) begin
			prod_s2 <= {{(PROD_W-SUM_W){1'b0}}, sum_s1} * {{(PROD_W-MULT_W){1'b0}}, mult_q};
			wide_s2 <= wide_s1;
			last_s2 <= last_s1;
		end
	end

	assign prod_shr      = prod_s2 >> shift_q;
	assign cv_push       = valid_s2 && !cv_full;
	assign cv_data.value = wide_s2 ? prod_shr[CVAL_W-1:0] : {1'b0, prod_shr[CVAL_W-2:0]};
	assign cv_data.wide  = wide_s2;
	assign cv_data.last  = last_s2;

endmodule
`default_nettype wire

// File: hdl/pvcp_fifo.sv
`default_nettype none
module pvcp_fifo #(
	parameter int unsigned DEPTH = pvcp_pkg::FIFO_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire pvcp_pkg::cval_t wdata,
	output logic                 full,
	input  wire logic            rd,
	output pvcp_pkg::cval_t      rdata,
	output logic                 empty
);
	import pvcp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	cval_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count above depth");

endmodule
`default_nettype wire

// File: hdl/pvcp_back.sv
`default_nettype none
module pvcp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pvcp_pkg::cval_t cv_data,
	input  wire logic            cv_empty,
	output logic                 cv_pop,
	output logic                 empty,
	input  wire logic            pop,
	output pvcp_pkg::out_item_t  result
);
	import pvcp_pkg::*;

	localparam int unsigned TOT_W = 5;
	localparam int unsigned BUF_W = ACC_W + CVAL_W;

	logic [ACC_W-1:0]     acc_q;
	logic [ACC_CNT_W-1:0] acc_cnt_q;
	logic [1:0]           ocnt_q;
	logic [BYTE_W-1:0]    byte0_q, byte1_q;
	logic                 last0_q, last1_q;

	logic [BUF_W-1:0]     merged;
	logic [TOT_W-1:0]     total;
	logic                 two;
	logic                 out_pop, take;

	// Merge the new value above the pending bits, LSB first.
	assign merged = {{CVAL_W{1'b0}}, acc_q} | ({{ACC_W{1'b0}}, cv_data.value} << acc_cnt_q);
	assign total  = {2'b0, acc_cnt_q} + (cv_data.wide ? 5'd11 : 5'd10);
	assign two    = (total >= 5'd16);

	assign empty   = (ocnt_q == 2'd0);
	assign out_pop = pop && !empty;
	assign take    = !cv_empty && (empty || (ocnt_q == 2'd1 && out_pop));
	assign cv_pop  = take;

	assign result.packed_byte = byte0_q;
	assign result.last_byte   = last0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			acc_cnt_q <= '0;
			ocnt_q    <= '0;
		end else if (take) begin
			ocnt_q <= two ? 2'd2 : 2'd1;
			if (cv_data.last) begin
				acc_q     <= '0;
				acc_cnt_q <= '0;
			end else begin
				acc_q     <= two ? {5'b0, merged[17:16]} : merged[14:8];
				acc_cnt_q <= total[ACC_CNT_W-1:0];
			end
		end else if (out_pop) begin
			ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte0_q <= merged[7:0];
			byte1_q <= merged[15:8];
			last0_q <= cv_data.last && !two;
			last1_q <= cv_data.last;
		end else if (out_pop) begin
			byte0_q <= byte1_q;
			last0_q <= last1_q;
		end
	end

	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("output holding register overfilled");

	a_vector_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && cv_data.last |=> acc_cnt_q == '0 && acc_q == '0)
		else $error("accumulator not cleared at vector end");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !empty)
		else $error("taken coefficient produced no byte");

endmodule
`default_nettype wire

// File: hdl/polyvec_compress_pack.sv
`default_nettype none
// Compresses a stream of signed 16-bit polynomial coefficients to 10 or 11 bits each and packs
// them LSB first into bytes. Push one coefficient per request; a negative value is first lifted
// by the modulus, then ((x << d) + rounding_offset) * barrett_multiplier >> product_shift is kept
// to d bits. Results leave as bytes, oldest first, and the final byte of a vector is flagged;
// bits left over at the vector end are dropped. A coefficient can be accepted every cycle
// while full is low, and one byte is delivered per cycle while pop is high, so the sustained
// coefficient rate is set by the single byte-wide result port. A pushed coefficient passes two
// pipeline stages (shift-add, then one 28x21 multiply), the queue and the output holding
// register. Configuration registers are written through wr_en/wr_index/wr_data and must be
// changed only while the block holds no request in flight.
module polyvec_compress_pack #(
	parameter int unsigned FIFO_DEPTH = pvcp_pkg::FIFO_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [pvcp_pkg::REG_INDEX_W-1:0]  wr_index,
	input  wire logic [pvcp_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire logic                              push,
	output logic                                   full,
	input  wire pvcp_pkg::in_item_t                item,
	output logic                                   empty,
	input  wire logic                              pop,
	output pvcp_pkg::out_item_t                    result
);
	import pvcp_pkg::*;

	// Compressed coefficients flow from the arithmetic front through a short queue
	// to the packer, so a stalled consumer does not stop the multiplier pipeline at once.
	cval_t cv_wdata, cv_rdata;
	logic  cv_push, cv_full, cv_pop, cv_empty;

	pvcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.full     (full),
		.item     (item),
		.cv_push  (cv_push),
		.cv_full  (cv_full),
		.cv_data  (cv_wdata)
	);

	pvcp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cv_push),
		.wdata  (cv_wdata),
		.full   (cv_full),
		.rd     (cv_pop),
		.rdata  (cv_rdata),
		.empty  (cv_empty)
	);

	// The packer keeps up to seven pending bits and holds at most two finished bytes.
	pvcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cv_data  (cv_rdata),
		.cv_empty (cv_empty),
		.cv_pop   (cv_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
`default_nettype wire
